/* design/itrt_pkg.sv */
// shared types, constants and helpers for the radix-to-text converter
package itrt_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned MAX_SYMBOLS_DEF = 16;

  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned REM_W     = 4;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned APB_DW    = 64;
  localparam int unsigned APB_AW    = 4;

  localparam logic [RADIX_W-1:0] SIGNED_RADIX = 5'd10;
  localparam logic [CHAR_W-1:0]  MINUS_CHAR   = 8'h2D;

  localparam logic [APB_DW-1:0] ALPHA_LOW_RST  = 64'd3978425819141910832;
  localparam logic [APB_DW-1:0] ALPHA_HIGH_RST = 64'd7378413942531504440;

  // register index is paddr[3]
  localparam logic REG_ALPHA_LOW  = 1'b0;
  localparam logic REG_ALPHA_HIGH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MINUS,
    ST_READ,
    ST_EMIT
  } itrt_state_e;

  // pick one byte of the 16-symbol alphabet
  function automatic logic [CHAR_W-1:0] symbol_at(input logic [APB_DW-1:0] alo,
                                                  input logic [APB_DW-1:0] ahi,
                                                  input logic [REM_W-1:0]  idx);
    logic [APB_DW-1:0] word;
    word = idx[3] ? ahi : alo;
    return word[{idx[2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

/* design/itrt_ram.sv */
// generic single-write, single-read ram with registered read data
module itrt_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/itrt_divider.sv */
// bit-serial restoring divider, one quotient bit per cycle
module itrt_divider import itrt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [RADIX_W-1:0]     divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [REM_W-1:0]       remainder_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [RADIX_W-1:0]     div_q;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [RADIX_W-1:0]     trial;
  logic [RADIX_W-1:0]     diff;
  logic                   ge;

  // shift in next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign ge    = (trial >= div_q);
  assign diff  = trial - div_q;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CNT_W'(VALUE_WIDTH);
    end else if (cnt_q != '0) begin
      quo_d  = {quo_q[VALUE_WIDTH-2:0], ge};
      rem_d  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* design/integer_radix_to_text.sv */
// top level: integer to text conversion in a configurable radix
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+----------------------------
//  in      | in_valid_i/in_ready_o, value_i,           | one number to convert
//          | is_signed_i, radix_i                      |
//  out     | out_valid_o/out_ready_i, character_o,     | one character, last_o on
//          | last_o                                    | the final one
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | alphabet_low at 0x0,
//          | prdata, pready                            | alphabet_high at 0x8
//
// each digit is one division in the shared bit-serial divider,
// each digit character then takes a ram read and an output load, the minus character only an output load
// in_ready_o is high only in idle; radix 0 or 1 is taken and dropped, and the block stays idle
// reset is asynchronous active low, restores the default alphabet, no sweep needed
// a stalled output beat holds the emit sequencer, the divider is already done
module integer_radix_to_text import itrt_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input beat
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   is_signed_i,
  input  logic [RADIX_W-1:0]     radix_i,
  // output beat
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CHAR_W-1:0]      character_o,
  output logic                   last_o,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int unsigned AW = $clog2(VALUE_WIDTH);
  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DW = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;

  itrt_state_e state_q, state_d;

  logic [APB_DW-1:0]      alo_q, ahi_q;
  logic                   neg_q;
  logic [RADIX_W-1:0]     radix_q;
  logic [CW-1:0]          dcnt_q;
  logic [AW-1:0]          rd_idx_q;
  logic                   out_valid_q;
  logic [CHAR_W-1:0]      char_q;
  logic                   last_q;

  logic                   in_fire;
  logic                   out_free;
  logic [RADIX_W-1:0]     radix_sat;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] magnitude;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [REM_W-1:0]       div_rem;

  logic                   ram_we;
  logic [DW-1:0]          ram_rdata;
  logic                   load_minus;
  logic                   load_digit;
  logic                   cfg_wr;

  // ---------------------------------------------------------------- config
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_ALPHA_HIGH) ? ahi_q : alo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alo_q <= ALPHA_LOW_RST;
      ahi_q <= ALPHA_HIGH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_ALPHA_LOW:  alo_q <= pwdata;
        REG_ALPHA_HIGH: ahi_q <= pwdata;
        default:        alo_q <= alo_q;
      endcase
    end
  end

  // ---------------------------------------------------------------- input prep
  // radix above the alphabet size saturates
  assign radix_sat = (radix_i > RADIX_W'(MAX_SYMBOLS)) ? RADIX_W'(MAX_SYMBOLS) : radix_i;
  // minus only for signed base ten with the sign bit set
  assign neg       = is_signed_i && (radix_sat == SIGNED_RADIX) && value_i[VALUE_WIDTH-1];
  assign magnitude = neg ? (~value_i + 1'b1) : value_i;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quo;
    ram_we       = 1'b0;
    load_minus   = 1'b0;
    load_digit   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        div_dividend = magnitude;
        if (in_valid_i && (radix_sat > RADIX_W'(1))) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // remainder is the next digit, least significant first
          ram_we = 1'b1;
          if (div_quo == '0) begin
            state_d = neg_q ? ST_MINUS : ST_READ;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_MINUS: begin
        if (out_free) begin
          load_minus = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        // ram read data lands next cycle
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load_digit = 1'b1;
          state_d    = (rd_idx_q == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q    <= 1'b0;
      radix_q  <= '0;
      dcnt_q   <= '0;
      rd_idx_q <= '0;
    end else begin
      if (in_fire) begin
        neg_q   <= neg;
        radix_q <= radix_sat;
        dcnt_q  <= '0;
      end
      if (ram_we) begin
        dcnt_q   <= dcnt_q + 1'b1;
        rd_idx_q <= dcnt_q[AW-1:0];
      end else if (load_digit) begin
        rd_idx_q <= rd_idx_q - 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  itrt_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (in_ready_o ? radix_sat : radix_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // digit store, written in ascending order, read back descending
  itrt_ram #(
    .WIDTH (DW),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (dcnt_q[AW-1:0]),
    .wdata_i (div_rem[DW-1:0]),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_minus || load_digit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_minus) begin
      char_q <= MINUS_CHAR;
      last_q <= 1'b0;
    end else if (load_digit) begin
      char_q <= symbol_at(alo_q, ahi_q, REM_W'(ram_rdata));
      last_q <= (rd_idx_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

/* design/itrt_checker.sv */
// port-level checks for the radix-to-text converter, bound to the top level
module itrt_checker import itrt_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [RADIX_W-1:0]     radix_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [CHAR_W-1:0]      character_o,
  input logic                   last_o,
  input logic                   pready
);

  // a convertible number blocks further input while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (radix_i > RADIX_W'(1)) |=> !in_ready_o)
    else $error("input still ready after accepting a number");

  // radix 0 or 1 produces nothing and leaves the block ready
  a_no_output_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (radix_i <= RADIX_W'(1)) |=> in_ready_o)
    else $error("block went busy on radix below two");

  // no new number is taken while a non-final character is pending
  a_no_input_mid_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready in the middle of a number");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(character_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind integer_radix_to_text itrt_checker u_itrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .radix_i     (radix_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .character_o (character_o),
  .last_o      (last_o),
  .pready      (pready)
);
